// ===== src/aes_ctr_pkg.sv =====
// shared types, constants and functions for the aes counter-mode byte stream core
package aes_ctr_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEXP,
      ST_LOAD,
      ST_ROUND,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic kexp_start;
      logic kexp_step;
      logic enc_load;
      logic enc_step;
      logic ctr_reload;
      logic take_item;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic kexp_done;
      logic enc_done;
      logic need_block;
      logic need_kexp;
   } sts_type;

   localparam logic [2:0] CSR_KEY0  = 3'd0;
   localparam logic [2:0] CSR_KEY1  = 3'd1;
   localparam logic [2:0] CSR_KEY2  = 3'd2;
   localparam logic [2:0] CSR_KEY3  = 3'd3;
   localparam logic [2:0] CSR_KSIZE = 3'd4;
   localparam logic [2:0] CSR_NHI   = 3'd5;
   localparam logic [2:0] CSR_NLO   = 3'd6;

   localparam logic [1:0] KSIZE_128 = 2'd0;
   localparam logic [1:0] KSIZE_192 = 2'd1;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam int ROW_SRC [16] = '{0, 5, 10, 15, 4, 9, 14, 3, 8, 13, 2, 7, 12, 1, 6, 11};

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

endpackage

// ===== src/aes_ctr_ctrl.sv =====
// controller state machine sequencing key expansion, block encryption and result transfer
module aes_ctr_ctrl
   import aes_ctr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  logic    out_busy,
   input  sts_type sts,
   output logic    in_ready,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               if (sts.need_kexp) begin
                  state_in = ST_KEXP;
               end else if (sts.need_block) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_KEXP: begin
            if (sts.kexp_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD:  state_in = ST_ROUND;
         ST_ROUND: begin
            if (sts.enc_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.kexp_start = in_valid && sts.need_kexp;
            cmd.ctr_reload = in_valid && sts.need_kexp;
         end
         ST_KEXP:  cmd.kexp_step = !sts.kexp_done;
         ST_LOAD:  cmd.enc_load = 1'b1;
         ST_ROUND: cmd.enc_step = !sts.enc_done;
         ST_OUT: begin
            if (!out_busy) begin
               in_ready      = 1'b1;
               cmd.take_item = 1'b1;
               cmd.out_load  = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== src/aes_ctr_dp.sv =====
// datapath: key schedule, round keys, round unit, counter, keystream and output register
module aes_ctr_dp
   import aes_ctr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata,
   input  logic [7:0]  in_data,
   input  logic        in_restart,
   input  logic        out_ack,
   output logic        out_busy,
   output logic [7:0]  out_data,
   output sts_type     sts
);

   logic [63:0] key_ff [4];
   logic [1:0]  ksize_ff;
   logic [63:0] nhi_ff, nlo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '{default: '0};
         ksize_ff <= KSIZE_128;
         nhi_ff   <= '0;
         nlo_ff   <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_KEY0:  key_ff[0] <= csr_wdata;
            CSR_KEY1:  key_ff[1] <= csr_wdata;
            CSR_KEY2:  key_ff[2] <= csr_wdata;
            CSR_KEY3:  key_ff[3] <= csr_wdata;
            CSR_KSIZE: ksize_ff  <= csr_wdata[1:0];
            CSR_NHI:   nhi_ff    <= csr_wdata;
            CSR_NLO:   nlo_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // key schedule: a sliding window of nk words, one new word a cycle
   logic [31:0]  win_ff [8];
   logic [31:0]  win_in [8];
   logic [3:0]   nk_ff;
   logic [3:0]   rounds_ff;
   logic [5:0]   widx_ff;
   logic [5:0]   total_ff;
   logic [2:0]   mcnt_ff;
   logic [7:0]   rc_ff;
   logic         kbusy_ff;
   logic [127:0] rk_mem [15];
   logic [31:0]  wnew;
   logic [31:0]  wprev;
   logic [31:0]  tmp;
   logic [3:0]   nk_new;

   always_comb begin
      nk_new = (ksize_ff == KSIZE_128) ? 4'd4 : (ksize_ff == KSIZE_192) ? 4'd6 : 4'd8;
      wprev  = win_ff[nk_ff[2:0] - 3'd1];
      tmp    = wprev;
      if (mcnt_ff == 3'd0) begin
         tmp = sub_word({wprev[23:0], wprev[31:24]}) ^ {rc_ff, 24'd0};
      end else if (nk_ff == 4'd8 && mcnt_ff == 3'd4) begin
         tmp = sub_word(wprev);
      end
      wnew = win_ff[0] ^ tmp;
      for (int i = 0; i < 8; i++) begin
         win_in[i] = (i < 7) ? win_ff[i + 1] : 32'd0;
      end
      win_in[nk_ff[2:0] - 3'd1] = wnew;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kbusy_ff  <= 1'b0;
         rounds_ff <= 4'd10;
      end else if (cmd.kexp_start) begin
         kbusy_ff  <= 1'b1;
         rounds_ff <= nk_new + 4'd6;
      end else if (cmd.kexp_step && widx_ff == total_ff - 6'd1) begin
         kbusy_ff  <= 1'b0;
      end
   end

   // one round key of four words per entry, first word in the top bits
   always_ff @(posedge clock) begin
      if (cmd.kexp_start) begin
         for (int i = 0; i < 8; i++) begin
            win_ff[i] <= i[0] ? key_ff[i >> 1][31:0] : key_ff[i >> 1][63:32];
         end
         for (int i = 0; i < 8; i++) begin
            if (i < nk_new) begin
               rk_mem[i >> 2][127 - 32 * i[1:0] -: 32] <=
                  i[0] ? key_ff[i >> 1][31:0] : key_ff[i >> 1][63:32];
            end
         end
         nk_ff    <= nk_new;
         widx_ff  <= {2'd0, nk_new};
         total_ff <= {nk_new + 4'd7, 2'd0};
         mcnt_ff  <= 3'd0;
         rc_ff    <= 8'h01;
      end else if (cmd.kexp_step) begin
         win_ff <= win_in;
         rk_mem[widx_ff[5:2]][127 - 32 * widx_ff[1:0] -: 32] <= wnew;
         widx_ff <= widx_ff + 6'd1;
         mcnt_ff <= (mcnt_ff == nk_ff[2:0] - 3'd1) ? 3'd0 : mcnt_ff + 3'd1;
         if (mcnt_ff == 3'd0) begin
            rc_ff <= xtime(rc_ff);
         end
      end
   end

   // round unit: one aes round a cycle
   logic [127:0] ctr_ff;
   logic [127:0] state_ff;
   logic [127:0] ks_ff;
   logic [3:0]   rnd_ff;
   logic [3:0]   pos_ff;
   logic         kready_ff;
   logic [127:0] rk_cur;
   logic [127:0] sb;
   logic [127:0] mc;
   logic [127:0] rnd_out;
   logic [7:0]   a [4];
   logic [7:0]   b [4];

   always_comb begin
      rk_cur = rk_mem[rnd_ff];
      for (int i = 0; i < 16; i++) begin
         sb[127 - 8 * i -: 8] = SBOX[state_ff[127 - 8 * ROW_SRC[i] -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            a[j] = sb[127 - 8 * (4 * c + j) -: 8];
            b[j] = xtime(a[j]);
         end
         for (int j = 0; j < 4; j++) begin
            mc[127 - 8 * (4 * c + j) -: 8] = b[j] ^ a[(j + 1) % 4] ^ b[(j + 1) % 4]
                                             ^ a[(j + 2) % 4] ^ a[(j + 3) % 4];
         end
      end
      rnd_out = ((rnd_ff == rounds_ff) ? sb : mc) ^ rk_cur;
   end

   always_ff @(posedge clock) begin
      if (cmd.enc_load) begin
         state_ff <= ctr_ff ^ rk_cur;
         rnd_ff   <= 4'd1;
      end else if (cmd.enc_step) begin
         state_ff <= rnd_out;
         rnd_ff   <= (rnd_ff == rounds_ff) ? 4'd0 : rnd_ff + 4'd1;
         if (rnd_ff == rounds_ff) begin
            ks_ff <= rnd_out;
         end
      end else if (cmd.kexp_start) begin
         rnd_ff <= 4'd0;
      end
   end

   logic enc_fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff     <= '0;
         pos_ff     <= '0;
         kready_ff  <= 1'b0;
         enc_fin_ff <= 1'b0;
      end else begin
         if (cmd.ctr_reload) begin
            ctr_ff    <= {nhi_ff, nlo_ff};
            pos_ff    <= '0;
            kready_ff <= 1'b1;
         end else if (cmd.enc_step && rnd_ff == rounds_ff) begin
            ctr_ff <= ctr_ff + 128'd1;
         end
         if (cmd.enc_load) begin
            enc_fin_ff <= 1'b0;
         end else if (cmd.enc_step && rnd_ff == rounds_ff) begin
            enc_fin_ff <= 1'b1;
         end
         if (cmd.take_item) begin
            pos_ff <= pos_ff + 4'd1;
         end
      end
   end

   logic       ovalid_ff;
   logic [7:0] odata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         ovalid_ff <= 1'b1;
      end else if (out_ack) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         odata_ff <= in_data ^ ks_ff[127 - 8 * pos_ff -: 8];
      end
   end

   assign out_busy       = ovalid_ff && !out_ack;
   assign out_data       = odata_ff;
   assign sts.kexp_done  = !kbusy_ff;
   assign sts.enc_done   = enc_fin_ff;
   assign sts.need_kexp  = in_restart || !kready_ff;
   assign sts.need_block = (pos_ff == 4'd0);

endmodule

// ===== src/aes_ctr_byte_stream_core.sv =====
// top level of the aes counter-mode byte stream core
// a byte at a non-zero position goes from idle to the output state and is taken there once the
// output register is free, its result registered; a byte at position zero first passes the load
// and round states, and a restart adds the key schedule, one word a cycle, before them
// each byte passes the controller's idle and output states, so the next waits until the last is taken
// reset is synchronous and active high; it clears control, counter and configuration
module aes_ctr_byte_stream_core
   import aes_ctr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;
   logic    out_busy;
   logic    ovalid_ff;

   aes_ctr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .out_busy (out_busy),
      .sts      (sts),
      .in_ready (req_tready),
      .cmd      (cmd)
   );

   aes_ctr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .in_data    (req_tdata),
      .in_restart (req_tuser),
      .out_ack    (rsp_tready),
      .out_busy   (out_busy),
      .out_data   (rsp_tdata),
      .sts        (sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         ovalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         ovalid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = ovalid_ff;

endmodule

// ===== src/aes_ctr_checker.sv =====
// port-level checker for the aes counter-mode byte stream core, with its bind
module aes_ctr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_ready_needs_valid: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> req_tvalid)
      else $error("ready raised with no item offered");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item produced no result");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item taken while result pending");

endmodule

bind aes_ctr_byte_stream_core aes_ctr_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
